// ===== rtl/nqueens_subtree_counter_core_assert.svh =====
// assertion macros for the checker file
`ifndef NQUEENS_SUBTREE_COUNTER_CORE_ASSERT_SVH
`define NQUEENS_SUBTREE_COUNTER_CORE_ASSERT_SVH

// concurrent check, silent while reset is held
`define NQSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs across reset
`define NQSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nqsc_pkg.sv =====
package nqsc_pkg;

    localparam int MAX_BOARD_DEF = 21;
    localparam int FIELD_W       = 21;
    localparam int SIZE_W        = 5;
    localparam int ROW_W         = 5;
    localparam int COUNT_W       = 40;

    localparam logic [SIZE_W-1:0]  BOARD_RESET = SIZE_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_POP,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/nqsc_frame_ram.sv =====
module nqsc_frame_ram #(
    parameter int DEPTH  = 21,
    parameter int WIDTH  = 84,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/nqueens_subtree_counter_core.sv =====
// Counts the completions of one partial N-queens board by bitwise backtracking and
// returns twice that count (mirror images), saturating at 2^40-1. Board width comes
// from the board width register (reset 8, clamped to MAX_BOARD); mask bits above it
// are ignored. One board is searched at a time: a step that places a queen one row
// deeper stays in the search state; a step that backs up a row passes through the
// pop state, as the saved frame comes back through the registered read of the frame
// memory (depth MAX_BOARD, one entry per level). The board is loaded from idle, and
// the finish state hands the count to the output register. The next board is
// accepted as soon as the count sits in the output register, whether or not it has
// been taken yet.
module nqueens_subtree_counter_core
    import nqsc_pkg::*;
#(
    parameter int MAX_BOARD = MAX_BOARD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SIZE_W-1:0]  i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ROW_W-1:0]   i_start_row,
    input  logic [FIELD_W-1:0] i_column_mask,
    input  logic [FIELD_W-1:0] i_right_diag_mask,
    input  logic [FIELD_W-1:0] i_left_diag_mask,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COUNT_W-1:0] o_solution_count
);

    localparam int LVL_W   = $clog2(MAX_BOARD);
    localparam int FRAME_W = 4 * MAX_BOARD;
    localparam logic [SIZE_W:0]  MAX_N    = (SIZE_W + 1)'(MAX_BOARD);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(MAX_BOARD - 1);

    t_state r_state, n_state;
    logic [SIZE_W-1:0]    r_board_width;
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;

    logic [MAX_BOARD-1:0] r_col, n_col;
    logic [MAX_BOARD-1:0] r_rd, n_rd;
    logic [MAX_BOARD-1:0] r_ld, n_ld;
    logic [MAX_BOARD-1:0] r_cand, n_cand;
    logic [LVL_W-1:0]     r_level, n_level;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [COUNT_W-1:0]   r_count, n_count;

    logic [SIZE_W:0]      n_eff;
    logic [MAX_BOARD-1:0] full;
    logic [MAX_BOARD-1:0] lsb, rest;
    logic [MAX_BOARD-1:0] dn_col, dn_rd, dn_ld;
    logic [MAX_BOARD-1:0] in_col, in_rd, in_ld;
    logic [MAX_BOARD+FIELD_W-1:0] ext_col, ext_rd, ext_ld;
    logic                 can_descend;
    logic                 load_out;

    logic                 ram_we, ram_re;
    logic [LVL_W-1:0]     ram_raddr;
    logic [FRAME_W-1:0]   ram_wdata, ram_rdata;

    nqsc_frame_ram #(
        .DEPTH  (MAX_BOARD),
        .WIDTH  (FRAME_W),
        .ADDR_W (LVL_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_level),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // effective width and the mask of N ones
    always_comb begin
        n_eff = (r_board_width > MAX_N[SIZE_W-1:0] && MAX_N[SIZE_W] == 1'b0) ?
                MAX_N : {1'b0, r_board_width};
        for (int i = 0; i < MAX_BOARD; i++) begin
            full[i] = ((SIZE_W + 1)'(i) < n_eff);
        end
    end

    // fit the fixed-width input masks to MAX_BOARD
    assign ext_col = {{MAX_BOARD{1'b0}}, i_column_mask};
    assign ext_rd  = {{MAX_BOARD{1'b0}}, i_right_diag_mask};
    assign ext_ld  = {{MAX_BOARD{1'b0}}, i_left_diag_mask};
    assign in_col  = ext_col[MAX_BOARD-1:0];
    assign in_rd   = ext_rd[MAX_BOARD-1:0];
    assign in_ld   = ext_ld[MAX_BOARD-1:0];

    assign lsb    = r_cand & (~r_cand + MAX_BOARD'(1));
    assign rest   = r_cand & ~lsb;
    assign dn_col = r_col | lsb;
    assign dn_rd  = (r_rd | lsb) >> 1;
    assign dn_ld  = (r_ld | lsb) << 1;

    // row + 1 < N means the current row is not the last one
    assign can_descend = (({1'b0, r_row} + (SIZE_W + 1)'(1)) < n_eff) && (r_level != LVL_LAST);
    assign ram_wdata   = {r_col, r_rd, r_ld, rest};
    assign load_out    = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_rd      = r_rd;
        n_ld      = r_ld;
        n_cand    = r_cand;
        n_level   = r_level;
        n_row     = r_row;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_level - LVL_W'(1);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_col   = in_col;
                    n_rd    = in_rd;
                    n_ld    = in_ld;
                    n_cand  = full & ~(in_col | in_rd | in_ld);
                    n_level = '0;
                    n_row   = i_start_row;
                    n_count = '0;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_cand != '0 && can_descend) begin
                    // save this level's frame and go one row deeper
                    ram_we  = 1'b1;
                    n_col   = dn_col;
                    n_rd    = dn_rd;
                    n_ld    = dn_ld;
                    n_cand  = full & ~(dn_col | dn_rd | dn_ld);
                    n_level = r_level + LVL_W'(1);
                    n_row   = r_row + ROW_W'(1);
                end else begin
                    if (r_cand != '0) begin
                        // queen in the last row: a solution, rest of the row dropped
                        n_count = (r_count >= COUNT_MAX - COUNT_W'(1)) ?
                                  COUNT_MAX : r_count + COUNT_W'(2);
                    end
                    if (r_level == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        ram_re  = 1'b1;
                        n_level = r_level - LVL_W'(1);
                        n_row   = r_row - ROW_W'(1);
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                n_col   = ram_rdata[4*MAX_BOARD-1:3*MAX_BOARD];
                n_rd    = ram_rdata[3*MAX_BOARD-1:2*MAX_BOARD];
                n_ld    = ram_rdata[2*MAX_BOARD-1:MAX_BOARD];
                n_cand  = ram_rdata[MAX_BOARD-1:0];
                n_state = ST_SEARCH;
            end
            ST_FINISH: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_width <= BOARD_RESET;
        end else if (i_cfg_we) begin
            r_board_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_rd    <= n_rd;
        r_ld    <= n_ld;
        r_cand  <= n_cand;
        r_level <= n_level;
        r_row   <= n_row;
        r_count <= n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_count <= r_count;
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_solution_count = r_out_count;

endmodule

// ===== rtl/nqsc_checker.sv =====
`include "nqueens_subtree_counter_core_assert.svh"

module nqsc_checker
    import nqsc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COUNT_W-1:0] o_solution_count
);

    // a stalled result transaction keeps its count
    `NQSC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_solution_count), "stalled result changed")

    // counts come in pairs unless saturated
    `NQSC_ASSERT(a_count_even, i_clk, i_rst_n, o_out_valid |-> (o_solution_count[0] == 1'b0) || (o_solution_count == COUNT_MAX), "odd unsaturated count")

    // one board at a time: an accepted transaction makes the core busy
    `NQSC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready right after accept")

    // reset empties the output register
    `NQSC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind nqueens_subtree_counter_core nqsc_checker u_nqsc_checker (.*);
